FILE: rtl/fsr64_pkg.sv
package fsr64_pkg;

  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  localparam int unsigned RES_DEPTH = 4;
  localparam int unsigned CNT_W     = $clog2(RES_DEPTH + 1);

  typedef struct packed {
    logic [7:0] data;
    logic       has_data;
    logic       last;
  } res_t;

  // 6-bit value to alphabet character: '-', '.', digits, upper, lower
  function automatic logic [7:0] enc_char(input logic [5:0] v);
    logic [7:0] w;
    logic [7:0] c;
    w = {2'b00, v};
    if (v < 6'd2) begin
      c = 8'h2D + w;
    end else if (v < 6'd12) begin
      c = 8'h30 + (w - 8'd2);
    end else if (v < 6'd38) begin
      c = 8'h41 + (w - 8'd12);
    end else begin
      c = 8'h61 + (w - 8'd38);
    end
    return c;
  endfunction

  // character to 6-bit value, anything outside the alphabet gives 0
  function automatic logic [5:0] dec_value(input logic [7:0] c);
    logic [7:0] w;
    w = 8'h00;
    if (c == 8'h2D) begin
      w = 8'd0;
    end else if (c == 8'h2E) begin
      w = 8'd1;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      w = c - 8'h30 + 8'd2;
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      w = c - 8'h41 + 8'd12;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      w = c - 8'h61 + 8'd38;
    end
    return w[5:0];
  endfunction

endpackage

FILE: rtl/filename_safe_radix64_codec_unit.sv
// channel   | dir | signals                                   | content
// s_axis    | in  | tvalid tready tdata[7:0] tlast            | name byte / character
// m_axis    | out | tvalid tready tdata[7:0] tuser[0] tlast   | character / byte, has_data
// cfg       | in  | cfg_wr_en cfg_wr_data                     | direction
//
// an accepted beat is worked out in the same cycle into a four-entry result register
// that shifts one result out per output beat; input is taken when no result waits or
// the one that waits leaves in the same cycle
// decode: one character per cycle while the output is not stalled; encode: a full group of three
// bytes gives four output beats, the fourth overlapping the next byte
// rst is synchronous and clears all state but the result entries; a stalled output blocks input
module filename_safe_radix64_codec_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,      // direction
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,     // in_byte[7:0]
  input  logic       s_axis_tlast,     // in_last
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,     // out_byte[7:0]
  output logic [0:0] m_axis_tuser,     // has_data[0]
  output logic       m_axis_tlast      // out_last
);

  logic                         direction;
  logic [1:0]                   phase;
  logic [15:0]                  held_bits;
  logic [fsr64_pkg::CNT_W-1:0]  rem;
  fsr64_pkg::res_t              ent [fsr64_pkg::RES_DEPTH];

  logic [1:0]                   phase_next;
  logic [15:0]                  held_next;
  logic [fsr64_pkg::CNT_W-1:0]  n_res;
  fsr64_pkg::res_t              ent_new [fsr64_pkg::RES_DEPTH];

  logic s_fire;
  logic m_fire;

  assign m_fire        = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (rem == '0) ||
                         ((rem == fsr64_pkg::CNT_W'(1)) && m_axis_tready);
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = (rem != '0);
  assign m_axis_tdata  = ent[0].data;
  assign m_axis_tuser  = ent[0].has_data;
  assign m_axis_tlast  = ent[0].last;

  always_comb begin
    logic [7:0] b0, b1, b2;
    logic [1:0] cnt;
    logic [5:0] v;
    logic [7:0] dbyte;
    logic       dhas;
    phase_next = phase;
    held_next  = held_bits;
    n_res      = '0;
    for (int i = 0; i < fsr64_pkg::RES_DEPTH; i++) begin
      ent_new[i] = '0;
    end
    b0 = s_axis_tdata;
    b1 = 8'h00;
    b2 = 8'h00;
    cnt = 2'd1;
    v = fsr64_pkg::dec_value(s_axis_tdata);
    dbyte = 8'h00;
    dhas = 1'b1;
    if (direction == fsr64_pkg::DIR_ENCODE) begin
      case (phase)
        2'd1: begin
          b0 = held_bits[7:0];
          b1 = s_axis_tdata;
          cnt = 2'd2;
        end
        2'd2: begin
          b0 = held_bits[15:8];
          b1 = held_bits[7:0];
          b2 = s_axis_tdata;
          cnt = 2'd3;
        end
        default: begin
          cnt = 2'd1;
        end
      endcase
      if (cnt != 2'd3 && !s_axis_tlast) begin
        held_next  = (cnt == 2'd1) ? {8'h00, b0} : {b0, b1};
        phase_next = cnt;
      end else begin
        ent_new[0] = '{fsr64_pkg::enc_char(b0[7:2]), 1'b1, 1'b0};
        ent_new[1] = '{fsr64_pkg::enc_char({b0[1:0], b1[7:4]}), 1'b1, 1'b0};
        ent_new[2] = '{fsr64_pkg::enc_char({b1[3:0], b2[7:6]}), 1'b1, 1'b0};
        ent_new[3] = '{fsr64_pkg::enc_char(b2[5:0]), 1'b1, s_axis_tlast};
        n_res      = fsr64_pkg::CNT_W'(4);
        phase_next = 2'd0;
        held_next  = '0;
      end
    end else begin
      case (phase)
        2'd0: begin
          held_next = {8'h00, v, 2'b00};
          dhas = 1'b0;
        end
        2'd1: begin
          dbyte = held_bits[7:0] | {6'b0, v[5:4]};
          held_next = {8'h00, v[3:0], 4'h0};
        end
        2'd2: begin
          dbyte = held_bits[7:0] | {4'b0, v[5:2]};
          held_next = {8'h00, v[1:0], 6'b0};
        end
        default: begin
          dbyte = held_bits[7:0] | {2'b0, v};
          held_next = '0;
        end
      endcase
      phase_next = phase + 2'd1;
      ent_new[0] = '{dbyte, dhas, s_axis_tlast};
      // without last and without a full byte nothing goes out
      n_res = (dhas || s_axis_tlast) ? fsr64_pkg::CNT_W'(1) : '0;
      if (s_axis_tlast) begin
        phase_next = 2'd0;
        held_next  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= fsr64_pkg::DIR_ENCODE;
      phase     <= 2'd0;
      held_bits <= '0;
      rem       <= '0;
    end else begin
      if (cfg_wr_en) begin
        direction <= cfg_wr_data;
        phase     <= 2'd0;
        held_bits <= '0;
      end else if (s_fire) begin
        phase     <= phase_next;
        held_bits <= held_next;
      end
      if (s_fire) begin
        rem <= n_res;
      end else if (m_fire) begin
        rem <= rem - fsr64_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      for (int i = 0; i < fsr64_pkg::RES_DEPTH; i++) begin
        ent[i] <= ent_new[i];
      end
    end else if (m_fire) begin
      for (int i = 0; i < fsr64_pkg::RES_DEPTH - 1; i++) begin
        ent[i] <= ent[i + 1];
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_enc_group: assert property (@(posedge clk) disable iff (rst)
    s_fire && !cfg_wr_en && direction == fsr64_pkg::DIR_ENCODE && s_axis_tlast
    |=> rem == fsr64_pkg::CNT_W'(4))
    else $error("final encode beat did not load four results");

  a_dec_single: assert property (@(posedge clk) disable iff (rst)
    s_fire && direction == fsr64_pkg::DIR_DECODE && s_axis_tlast
    |=> rem == fsr64_pkg::CNT_W'(1))
    else $error("final decode beat did not give exactly one result");

  a_last_is_tail: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> rem == fsr64_pkg::CNT_W'(1))
    else $error("last result is not the final entry");

  a_state_cleared: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> phase == 2'd0 && held_bits == '0)
    else $error("state not cleared while last result waits");
`endif

endmodule

FILE: sim/filename_safe_radix64_codec_checker.sv
module filename_safe_radix64_codec_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  input  logic       s_axis_tvalid,
  input  logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,     // in_byte[7:0]
  input  logic       s_axis_tlast,     // in_last
  input  logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  input  logic [7:0] m_axis_tdata,     // out_byte[7:0]
  input  logic [0:0] m_axis_tuser,     // has_data[0]
  input  logic       m_axis_tlast,     // out_last
  output int         fail_count,
  output int         expected_count
);
  timeunit 1ns;
  timeprecision 1ps;

  // characters in order of their 6-bit value
  string glyphs = "-.0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz";

  logic            dir_mode;
  logic [1:0]      group_phase;
  logic [15:0]     pending_bits;
  fsr64_pkg::res_t expected_results[$];

  function automatic logic [5:0] char_to_sextet(input logic [7:0] c);
    for (int i = 0; i < 64; i++) begin
      if (glyphs[i] == c) return i[5:0];
    end
    return 6'd0;
  endfunction

  task automatic push_result(input logic [7:0] data, input logic has_data,
                             input logic last);
    fsr64_pkg::res_t r;
    r.data     = data;
    r.has_data = has_data;
    r.last     = last;
    expected_results.push_back(r);
  endtask

  task automatic push_glyph(input logic [5:0] v, input logic last);
    push_result(glyphs[v], 1'b1, last);
  endtask

  task automatic predict_codec_beat(input logic [7:0] b, input logic last);
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    int         n_bytes;
    logic [5:0] v;
    logic       emitted;
    if (dir_mode == fsr64_pkg::DIR_ENCODE) begin
      b1 = 8'h00;
      b2 = 8'h00;
      case (group_phase)
        2'd1: begin
          b0 = pending_bits[7:0];
          b1 = b;
          n_bytes = 2;
        end
        2'd2: begin
          b0 = pending_bits[15:8];
          b1 = pending_bits[7:0];
          b2 = b;
          n_bytes = 3;
        end
        default: begin
          b0 = b;
          n_bytes = 1;
        end
      endcase
      if (n_bytes < 3 && !last) begin
        pending_bits = (n_bytes == 1) ? {8'h00, b0} : {b0, b1};
        group_phase  = n_bytes[1:0];
      end else begin
        // short final group is zero filled, still four characters
        push_glyph(b0[7:2], 1'b0);
        push_glyph({b0[1:0], b1[7:4]}, 1'b0);
        push_glyph({b1[3:0], b2[7:6]}, 1'b0);
        push_glyph(b2[5:0], last);
        group_phase  = 2'd0;
        pending_bits = 16'h0000;
      end
    end else begin
      v = char_to_sextet(b);
      emitted = 1'b1;
      case (group_phase)
        2'd0: begin
          pending_bits = {8'h00, v, 2'b00};
          emitted = 1'b0;
        end
        2'd1: begin
          push_result(pending_bits[7:0] | {6'b0, v[5:4]}, 1'b1, last);
          pending_bits = {8'h00, v[3:0], 4'h0};
        end
        2'd2: begin
          push_result(pending_bits[7:0] | {4'b0, v[5:2]}, 1'b1, last);
          pending_bits = {8'h00, v[1:0], 6'b0};
        end
        default: begin
          push_result(pending_bits[7:0] | {2'b0, v}, 1'b1, last);
          pending_bits = 16'h0000;
        end
      endcase
      group_phase = group_phase + 2'd1;
      if (last) begin
        // a name that ends without completing a byte gets an empty end marker
        if (!emitted) push_result(8'h00, 1'b0, 1'b1);
        group_phase  = 2'd0;
        pending_bits = 16'h0000;
      end
    end
  endtask

  always @(posedge clk) begin
    fsr64_pkg::res_t want;
    if (rst) begin
      dir_mode     = fsr64_pkg::DIR_ENCODE;
      group_phase  = 2'd0;
      pending_bits = 16'h0000;
      expected_results.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result beat: out_byte %h has_data %b out_last %b",
                 m_axis_tdata, m_axis_tuser[0], m_axis_tlast);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (m_axis_tdata !== want.data) begin
            $error("out_byte: expected %h, actual %h", want.data, m_axis_tdata);
            fail_count++;
          end
          if (m_axis_tuser[0] !== want.has_data) begin
            $error("has_data: expected %b, actual %b", want.has_data, m_axis_tuser[0]);
            fail_count++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("out_last: expected %b, actual %b", want.last, m_axis_tlast);
            fail_count++;
          end
        end
      end
      // direction write drops any name in progress
      if (cfg_wr_en) begin
        dir_mode     = cfg_wr_data;
        group_phase  = 2'd0;
        pending_bits = 16'h0000;
      end
      if (s_axis_tvalid && s_axis_tready) predict_codec_beat(s_axis_tdata, s_axis_tlast);
    end
    expected_count = expected_results.size();
  end

endmodule

FILE: sim/filename_safe_radix64_codec_unit_tb.sv
module filename_safe_radix64_codec_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLD   = 80;
  localparam int SETTLE      = 4;
  localparam int END_SETTLE  = 8;
  localparam int NAME_ITEMS  = 22;

  logic       clk;
  logic       rst;
  logic       cfg_wr_en;
  logic       cfg_wr_data;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;
  logic       s_axis_tlast;
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;
  logic [0:0] m_axis_tuser;
  logic       m_axis_tlast;

  int fail_count;
  int expected_count;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_request  = 0;
  int stall_cycles  = 0;

  string glyphs = "-.0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz";

  filename_safe_radix64_codec_unit DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  filename_safe_radix64_codec_checker codec_check (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tlast   (s_axis_tlast),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tuser   (m_axis_tuser),
    .m_axis_tlast   (m_axis_tlast),
    .fail_count     (fail_count),
    .expected_count (expected_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        hold_request  = 0;
        m_axis_tready = 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else begin
        m_axis_tready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_wr_en || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // called at a falling edge, returns at the falling edge after the beat is taken
  task automatic send_beat(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = b;
    s_axis_tlast  = last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic wait_results_done();
    s_axis_tvalid = 1'b0;
    while (expected_count != 0) @(negedge clk);
  endtask

  task automatic write_direction(input logic d);
    wait_results_done();
    // a name cut short leaves no result behind, so give the last beat time to settle
    repeat (SETTLE) @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = d;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
  endtask

  // mostly alphabet characters, some arbitrary bytes as noise
  function automatic logic [7:0] pick_char();
    if ($urandom_range(7) == 0) return 8'($urandom_range(255));
    return glyphs[$urandom_range(63)];
  endfunction

  task automatic send_name(input logic d, input int len);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      b = (d == fsr64_pkg::DIR_DECODE) ? pick_char() : 8'($urandom_range(255));
      send_beat(b, i == len - 1);
    end
  endtask

  initial begin
    int    sent;
    int    len;
    logic  d;
    rst           = 1'b1;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = fsr64_pkg::DIR_ENCODE;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tlast  = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_idle_pct = 15;
    recv_idle_pct = 64;

    write_direction(fsr64_pkg::DIR_ENCODE);
    send_beat(8'h00, 1'b1);
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h55, 1'b0);
    send_beat(8'hAA, 1'b0);
    send_beat(8'h01, 1'b1);
    // partial group, dropped by the direction write
    send_beat(8'h12, 1'b0);
    send_beat(8'h34, 1'b0);

    write_direction(fsr64_pkg::DIR_DECODE);
    send_beat("-", 1'b0);
    send_beat("z", 1'b0);
    send_beat("0", 1'b0);
    send_beat("9", 1'b0);
    send_beat("A", 1'b0);
    send_beat("Z", 1'b0);
    send_beat("a", 1'b0);
    send_beat(".", 1'b0);
    send_beat(8'h2F, 1'b0);
    send_beat(8'h7B, 1'b1);
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h40, 1'b1);
    send_beat(8'h3A, 1'b0);
    send_beat(8'h5B, 1'b0);
    send_beat(8'h60, 1'b0);
    send_beat(".", 1'b1);
    // a lone last character completes no byte
    send_beat("-", 1'b1);
    send_beat("-", 1'b0);
    send_beat("A", 1'b0);

    for (int p = 0; p < 3; p++) begin
      send_idle_pct = (p == 0) ? 15 : (p == 1) ? 64 : 0;
      recv_idle_pct = (p == 0) ? 64 : (p == 1) ? 15 : 0;
      for (int k = 0; k < 2; k++) begin
        d = (k == 0) ? fsr64_pkg::DIR_ENCODE : fsr64_pkg::DIR_DECODE;
        write_direction(d);
        // receiver backs off while names keep coming, so the input fills and stalls
        if (k == 0) hold_request = 1;
        sent = 0;
        while (sent < NAME_ITEMS) begin
          len = ($urandom_range(5) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
          send_name(d, len);
          sent += len;
          if ($urandom_range(4) == 0) wait_results_done();
        end
      end
    end

    wait_results_done();
    repeat (END_SETTLE) @(negedge clk);
    if (fail_count == 0 && expected_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/fsr64_pkg.sv
rtl/filename_safe_radix64_codec_unit.sv
sim/filename_safe_radix64_codec_checker.sv
sim/filename_safe_radix64_codec_unit_tb.sv
